### rtl/assert_macros.svh
// Assertion macros for the RTL files of the block; apd_back includes them.
// Both macros sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define APD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("apd assertion failed");
// Check that cons holds in the cycle after ante.
`define APD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("apd assertion failed");
`else
`define APD_ASSERT_SAME(label, ante, cons)
`define APD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/apd_pkg.sv
package apd_pkg;

	// Depth limits and growth step
	localparam int MIN_DEPTH_MS = 200;
	localparam int MAX_DEPTH_MS = 1200;
	localparam int STEP_MS      = 100;

	// Highest offset the depth range allows, saturated to the 4-bit field
	localparam int STEP_RAW = (MAX_DEPTH_MS > MIN_DEPTH_MS) ?
		(MAX_DEPTH_MS - MIN_DEPTH_MS) / STEP_MS : 0;
	localparam logic [3:0] STEP_LIMIT = (STEP_RAW > 15) ? 4'd15 : 4'(STEP_RAW);

	// Register indexes on the configuration port
	localparam logic [2:0] REG_ADAPTIVE_ENABLE  = 3'd0;
	localparam logic [2:0] REG_BASE_DEPTH_MS    = 3'd1;
	localparam logic [2:0] REG_WINDOW_LENGTH_MS = 3'd2;
	localparam logic [2:0] REG_RATE_THRESHOLD   = 3'd3;
	localparam logic [2:0] REG_DECAY_QUIET_MS   = 3'd4;

	typedef struct packed {
		logic [31:0] recovery_total;
		logic [31:0] time_ms;
	} obs_t;

	typedef struct packed {
		logic [15:0] effective_depth_ms;
		logic [3:0]  offset_step_count;
		logic [31:0] transition_count;
	} res_t;

	typedef struct packed {
		logic        adaptive_enable;
		logic [15:0] base_depth_ms;
		logic [15:0] window_length_ms;
		logic [7:0]  rate_threshold;
		logic [15:0] decay_quiet_ms;
	} cfg_t;

	typedef enum logic {
		KIND_BASELINE = 1'b0,
		KIND_UPDATE   = 1'b1
	} kind_t;

	// One classified item between front and back
	typedef struct packed {
		kind_t       kind;
		logic [31:0] delta;
		logic [31:0] now;
	} entry_t;

endpackage

### rtl/apd_front.sv
module apd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          obs_valid,
	output logic          obs_ready,
	input  apd_pkg::obs_t obs_data,
	input  logic          q_full,
	output logic          push,
	output apd_pkg::entry_t entry
);
	import apd_pkg::*;

	logic        baseline_taken_q;
	logic [31:0] prev_total_q;

	// Take an item whenever the queue has room
	assign obs_ready = !q_full;
	assign push      = obs_valid && obs_ready;

	// Classify: the first item only sets the baseline, later ones carry the delta
	always_comb begin
		entry.kind  = baseline_taken_q ? KIND_UPDATE : KIND_BASELINE;
		entry.delta = obs_data.recovery_total - prev_total_q;
		entry.now   = obs_data.time_ms;
	end

	// Track the previous counter value in either mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_taken_q <= 1'b0;
			prev_total_q     <= '0;
		end else if (push) begin
			baseline_taken_q <= 1'b1;
			prev_total_q     <= obs_data.recovery_total;
		end
	end

endmodule

### rtl/apd_queue.sv
module apd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  apd_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output apd_pkg::entry_t pop_entry
);
	import apd_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_entry = mem_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/apd_back.sv
`include "assert_macros.svh"
module apd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  apd_pkg::cfg_t   cfg,
	input  logic            q_not_empty,
	input  apd_pkg::entry_t q_entry,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_ready,
	output apd_pkg::res_t   res_data
);
	import apd_pkg::*;

	logic [31:0] win_start_q;
	logic [31:0] last_rec_q;
	logic [31:0] win_count_q;
	logic [3:0]  offset_q;
	logic [31:0] trans_q;
	logic        res_valid_q;
	res_t        res_q;

	logic [31:0] win_start_d;
	logic [31:0] last_rec_d;
	logic [31:0] win_count_d;
	logic [3:0]  offset_d;
	logic [31:0] trans_d;
	logic [32:0] sum;
	logic [20:0] eff;
	logic [15:0] depth_d;

	// Pop when the output register is free or being emptied
	assign pop       = q_not_empty && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Window, growth and decay update for one item
	always_comb begin
		win_start_d = win_start_q;
		last_rec_d  = last_rec_q;
		win_count_d = win_count_q;
		offset_d    = offset_q;
		trans_d     = trans_q;
		sum         = {1'b0, win_count_q} + {1'b0, q_entry.delta};
		if (q_entry.kind == KIND_BASELINE) begin
			win_start_d = q_entry.now;
			last_rec_d  = q_entry.now;
		end else if (cfg.adaptive_enable) begin
			if (q_entry.delta != 32'd0) begin
				win_count_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				last_rec_d  = q_entry.now;
			end
			if ((q_entry.now - win_start_q) >= {16'd0, cfg.window_length_ms}) begin
				win_start_d = q_entry.now;
				win_count_d = q_entry.delta;
			end
			if (win_count_d >= {24'd0, cfg.rate_threshold}) begin
				if (offset_d < STEP_LIMIT) begin
					offset_d = offset_d + 4'd1;
					trans_d  = trans_d + 32'd1;
				end
				win_count_d = 32'd0;
				win_start_d = q_entry.now;
			end
			if ((offset_d != 4'd0) &&
				((q_entry.now - last_rec_d) >= {16'd0, cfg.decay_quiet_ms})) begin
				offset_d   = offset_d - 4'd1;
				trans_d    = trans_d + 32'd1;
				last_rec_d = q_entry.now;
			end
		end
	end

	// Depth from base and offset, minimum first then maximum; base depth alone when adaptation is off
	always_comb begin
		eff = {5'd0, cfg.base_depth_ms} + 21'(offset_d) * 21'(STEP_MS);
		if (eff < 21'(MIN_DEPTH_MS)) begin
			eff = 21'(MIN_DEPTH_MS);
		end
		if (eff > 21'(MAX_DEPTH_MS)) begin
			eff = 21'(MAX_DEPTH_MS);
		end
		depth_d = cfg.adaptive_enable ? eff[15:0] : cfg.base_depth_ms;
	end

	// Hold adaptation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			last_rec_q  <= '0;
			win_count_q <= '0;
			offset_q    <= '0;
			trans_q     <= '0;
		end else if (pop) begin
			win_start_q <= win_start_d;
			last_rec_q  <= last_rec_d;
			win_count_q <= win_count_d;
			offset_q    <= offset_d;
			trans_q     <= trans_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.effective_depth_ms <= depth_d;
			res_q.offset_step_count  <= offset_d;
			res_q.transition_count   <= trans_d;
		end
	end

	`APD_ASSERT_SAME(a_offset_limit, 1'b1, offset_q <= STEP_LIMIT)
	`APD_ASSERT_NEXT(a_pop_fills_out, pop, res_valid_q)
	`APD_ASSERT_NEXT(a_stall_holds_state, res_valid_q && !res_ready,
		$stable(offset_q) && $stable(trans_q) && $stable(win_count_q))

endmodule

### rtl/adaptive_prebuffer_depth_unit.sv
// Path: item, two-entry queue, output register. Throughput: one item per cycle
// while res_ready is high; the queue parts the classifier from the window/offset
// update, which commits one item per cycle unless the output stalls. Reset:
// arst_n clears control state asynchronously (not queue or result data) and
// restores register defaults; the next item after reset only takes the baseline.
module adaptive_prebuffer_depth_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          obs_valid,
	output logic          obs_ready,
	input  apd_pkg::obs_t obs_data,
	output logic          res_valid,
	input  logic          res_ready,
	output apd_pkg::res_t res_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import apd_pkg::*;

	cfg_t   cfg_q;
	logic   q_full;
	logic   q_not_empty;
	logic   push;
	logic   pop;
	entry_t push_entry;
	entry_t pop_entry;
	logic   wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adaptive_enable  <= 1'b0;
			cfg_q.base_depth_ms    <= 16'd500;
			cfg_q.window_length_ms <= 16'd10000;
			cfg_q.rate_threshold   <= 8'd3;
			cfg_q.decay_quiet_ms   <= 16'd30000;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_ADAPTIVE_ENABLE:  cfg_q.adaptive_enable  <= pwdata[0];
				REG_BASE_DEPTH_MS:    cfg_q.base_depth_ms    <= pwdata[15:0];
				REG_WINDOW_LENGTH_MS: cfg_q.window_length_ms <= pwdata[15:0];
				REG_RATE_THRESHOLD:   cfg_q.rate_threshold   <= pwdata[7:0];
				REG_DECAY_QUIET_MS:   cfg_q.decay_quiet_ms   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		case (paddr[4:2])
			REG_ADAPTIVE_ENABLE:  prdata = {31'd0, cfg_q.adaptive_enable};
			REG_BASE_DEPTH_MS:    prdata = {16'd0, cfg_q.base_depth_ms};
			REG_WINDOW_LENGTH_MS: prdata = {16'd0, cfg_q.window_length_ms};
			REG_RATE_THRESHOLD:   prdata = {24'd0, cfg_q.rate_threshold};
			REG_DECAY_QUIET_MS:   prdata = {16'd0, cfg_q.decay_quiet_ms};
			default:              prdata = 32'd0;
		endcase
	end

	apd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.obs_valid (obs_valid),
		.obs_ready (obs_ready),
		.obs_data  (obs_data),
		.q_full    (q_full),
		.push      (push),
		.entry     (push_entry)
	);

	apd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.pop_entry  (pop_entry)
	);

	apd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_entry     (pop_entry),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_data    (res_data)
	);

endmodule
